FILE: rtl/polygon_frustum_clipper_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the polygon frustum clipper
// Shared property shapes used by the clipper modules.
// ---------------------------------------------------------------------------
`ifndef POLYGON_FRUSTUM_CLIPPER_MACROS_SVH
`define POLYGON_FRUSTUM_CLIPPER_MACROS_SVH

// Condition c must hold in the same cycle as a.
`define PCC_ASSERT_SAME(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Condition c must hold in the cycle after a.
`define PCC_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

FILE: rtl/pfc_pkg.sv
// ---------------------------------------------------------------------------
// Polygon frustum clipper package
// Shared types, constants and the plane distance function.
// ---------------------------------------------------------------------------
package pfc_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int QDEPTH           = 4;
  localparam int QAW              = 2;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic signed [31:0] s;
  } vtx_t;

  typedef struct packed {
    vtx_t vtx;
    logic in_view;
    logic keep;
    logic last;
  } q_entry_t;

  typedef enum logic [2:0] {
    PL_FRONT  = 3'd0,
    PL_LEFT   = 3'd1,
    PL_RIGHT  = 3'd2,
    PL_BOTTOM = 3'd3,
    PL_TOP    = 3'd4
  } plane_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_PASS_RD,
    ST_CUR_WAIT,
    ST_NXT_RD,
    ST_NXT_WAIT,
    ST_DECIDE,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_IWRITE,
    ST_NEXT,
    ST_EMIT_RD,
    ST_EMIT_WAIT,
    ST_EMIT_HOLD,
    ST_EMPTY
  } bstate_t;

  // Distance-like value of a vertex against one plane; not negative means inside.
  function automatic logic signed [33:0] plane_f(plane_t p, vtx_t v, logic signed [31:0] nz);
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic signed [33:0] n;
    logic signed [33:0] r;
    x = $signed({{2{v.x[31]}}, v.x});
    y = $signed({{2{v.y[31]}}, v.y});
    z = $signed({{2{v.z[31]}}, v.z});
    n = $signed({{2{nz[31]}}, nz});
    case (p)
      PL_FRONT:  r = n - z;
      PL_LEFT:   r = x - z;
      PL_RIGHT:  r = -x - z;
      PL_BOTTOM: r = y - z;
      default:   r = -y - z;
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/pfc_front.sv
// ---------------------------------------------------------------------------
// Clipper front end
// Accepts vertices, classifies them against all planes and marks overflow.
// ---------------------------------------------------------------------------
module pfc_front #(
  parameter int MAX_VERTICES = pfc_pkg::MAX_VERTICES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic signed [31:0]  nz,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  vx,
  input  logic signed [31:0]  vy,
  input  logic signed [31:0]  vz,
  input  logic signed [31:0]  vw,
  input  logic signed [31:0]  vshade,
  input  logic                vlast,
  input  logic                q_full,
  output logic                q_push,
  output pfc_pkg::q_entry_t   q_data
);
  import pfc_pkg::*;

  localparam int CW = $clog2(MAX_VERTICES + 1);

  logic [CW-1:0] cnt;
  logic          in_view;
  vtx_t          v;

  assign v = '{x: vx, y: vy, z: vz, w: vw, s: vshade};

  always_comb begin
    in_view = 1'b1;
    for (int p = 0; p < 5; p++) begin
      if (plane_f(plane_t'(3'(p)), v, nz) < 0) in_view = 1'b0;
    end
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.vtx     = v;
    q_data.in_view = in_view;
    q_data.keep    = cnt < CW'(MAX_VERTICES);
    q_data.last    = vlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (q_push) begin
      if (vlast) cnt <= '0;
      else if (q_data.keep) cnt <= cnt + CW'(1);
    end
  end

endmodule

FILE: rtl/pfc_fifo.sv
// ---------------------------------------------------------------------------
// Clipper vertex queue
// Short first-in first-out queue between the front end and the clip engine.
// ---------------------------------------------------------------------------
module pfc_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  pfc_pkg::q_entry_t wdata,
  output logic              full,
  input  logic              pop,
  output pfc_pkg::q_entry_t rdata,
  output logic              empty
);
  import pfc_pkg::*;

  q_entry_t       mem [QDEPTH];
  logic [QAW-1:0] wp;
  logic [QAW-1:0] rp;
  logic [QAW:0]   cnt;

  assign full  = cnt == (QAW+1)'(QDEPTH);
  assign empty = cnt == '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + QAW'(1);
      if (pop) rp <= rp + QAW'(1);
      cnt <= cnt + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule

FILE: rtl/pfc_back.sv
// ---------------------------------------------------------------------------
// Clip engine
// Stores a polygon, runs up to five clip passes and sends the result vertices.
// ---------------------------------------------------------------------------
module pfc_back #(
  parameter int MAX_VERTICES = pfc_pkg::MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = pfc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic signed [31:0] nz,
  input  logic               q_empty,
  input  pfc_pkg::q_entry_t  q_data,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] ox,
  output logic signed [31:0] oy,
  output logic signed [31:0] oz,
  output logic signed [31:0] ow,
  output logic signed [31:0] oshade,
  output logic               olast,
  output logic               empty_res
);
  import pfc_pkg::*;

  localparam int MAX_RES = MAX_VERTICES + 5;
  localparam int DEPTH   = 2 * MAX_RES;
  localparam int AW      = $clog2(DEPTH);
  localparam int IW      = $clog2(MAX_RES + 1);
  localparam int TW      = FRAC_BITS + 1;
  localparam int DCW     = $clog2(FRAC_BITS + 1);
  localparam int PW      = 33 + TW + 1;
  localparam logic [31:0] ONE32 = 32'(1) << FRAC_BITS;

  function automatic logic [AW-1:0] addr(logic bank, logic [IW-1:0] i);
    return bank ? AW'(MAX_RES + int'(i)) : AW'(i);
  endfunction

  function automatic logic signed [31:0] field_of(vtx_t v, logic [1:0] f);
    case (f)
      2'd0:    return v.x;
      2'd1:    return v.y;
      2'd2:    return v.z;
      default: return v.s;
    endcase
  endfunction

  vtx_t mem [DEPTH];
  vtx_t rd_data;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] waddr;
  logic          mem_we;
  vtx_t          wdata;

  bstate_t st, st_next;
  logic [IW-1:0] n, k, idx;
  plane_t        plane;
  logic          sb;
  logic          all_in;
  logic          out_v;
  vtx_t          cur, nxt, ivtx;
  logic [35:0]   rem;
  logic [34:0]   dvs;
  logic [TW-1:0] q;
  logic [DCW-1:0] dcnt;
  logic [1:0]    fld;
  logic signed [PW-1:0] prod;

  logic signed [33:0] fcur, fnxt;
  logic signed [34:0] den;
  logic cin, nin, cur_room, k_w_room;
  logic [IW-1:0] k_w, n_after;
  logic [35:0] trial;
  logic        ge;
  logic signed [32:0] diff;
  logic signed [PW-1:0] sum;
  logic signed [31:0] sfld;
  logic signed [31:0] nfld;

  assign fcur = plane_f(plane, cur, nz);
  assign fnxt = plane_f(plane, nxt, nz);
  assign cin  = !fcur[33];
  assign nin  = !fnxt[33];
  assign den  = $signed({fcur[33], fcur}) - $signed({fnxt[33], fnxt});
  assign cur_room = k < IW'(MAX_RES);
  assign k_w  = k + IW'(cin && cur_room);
  assign k_w_room = k_w < IW'(MAX_RES);
  assign n_after = n + IW'(q_data.keep);

  assign trial = (dcnt == '0) ? rem : {rem[34:0], 1'b0};
  assign ge    = trial >= {1'b0, dvs};
  assign sfld  = field_of(cur, fld);
  assign nfld  = field_of(nxt, fld);
  assign diff  = $signed({nfld[31], nfld}) - $signed({sfld[31], sfld});
  assign sum   = $signed({{(PW-32){sfld[31]}}, sfld}) + (prod >>> FRAC_BITS);

  // Polygon store, two banks used alternately by the clip passes.
  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    st_next = st;
    case (st)
      ST_LOAD: begin
        if (!q_empty && q_data.last) begin
          if (all_in && (q_data.in_view || !q_data.keep)) st_next = ST_EMIT_RD;
          else st_next = ST_PASS_RD;
        end
      end
      ST_PASS_RD:   st_next = ST_CUR_WAIT;
      ST_CUR_WAIT:  st_next = ST_NXT_RD;
      ST_NXT_RD:    st_next = ST_NXT_WAIT;
      ST_NXT_WAIT:  st_next = ST_DECIDE;
      ST_DECIDE:    st_next = ((cin != nin) && k_w_room) ? ST_DIV : ST_NEXT;
      ST_DIV:       st_next = (dcnt == DCW'(FRAC_BITS)) ? ST_MUL : ST_DIV;
      ST_MUL:       st_next = ST_ACC;
      ST_ACC:       st_next = (fld == 2'd3) ? ST_IWRITE : ST_MUL;
      ST_IWRITE:    st_next = ST_NEXT;
      ST_NEXT: begin
        if (idx + IW'(1) != n) st_next = ST_NXT_RD;
        else if (k == '0) st_next = ST_EMPTY;
        else if (plane == PL_TOP) st_next = ST_EMIT_RD;
        else st_next = ST_PASS_RD;
      end
      ST_EMIT_RD:   st_next = ST_EMIT_WAIT;
      ST_EMIT_WAIT: st_next = ST_EMIT_HOLD;
      ST_EMIT_HOLD: begin
        if (!out_stall) st_next = olast ? ST_LOAD : ST_EMIT_RD;
      end
      ST_EMPTY:     st_next = ST_EMIT_HOLD;
      default:      st_next = ST_LOAD;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    mem_we  = 1'b0;
    waddr   = '0;
    wdata   = cur;
    rd_addr = '0;
    case (st)
      ST_LOAD: begin
        q_pop  = !q_empty;
        mem_we = !q_empty && q_data.keep;
        waddr  = addr(1'b0, n);
        wdata  = q_data.vtx;
      end
      ST_PASS_RD: rd_addr = addr(sb, n - IW'(1));
      ST_NXT_RD:  rd_addr = addr(sb, idx);
      ST_EMIT_RD: rd_addr = addr(sb, idx);
      ST_DECIDE: begin
        mem_we = cin && cur_room;
        waddr  = addr(!sb, k);
        wdata  = cur;
      end
      ST_IWRITE: begin
        mem_we  = 1'b1;
        waddr   = addr(!sb, k);
        wdata   = ivtx;
        wdata.w = $signed(ONE32);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) st <= ST_LOAD;
    else st <= st_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n      <= '0;
      k      <= '0;
      idx    <= '0;
      plane  <= PL_FRONT;
      sb     <= 1'b0;
      all_in <= 1'b1;
      out_v  <= 1'b0;
    end else begin
      case (st)
        ST_LOAD: begin
          if (!q_empty) begin
            n      <= n_after;
            all_in <= all_in && (q_data.in_view || !q_data.keep);
            idx    <= '0;
            k      <= '0;
            plane  <= PL_FRONT;
            sb     <= 1'b0;
          end
        end
        ST_DECIDE: k <= k_w;
        ST_IWRITE: k <= k + IW'(1);
        ST_NEXT: begin
          if (idx + IW'(1) != n) begin
            idx <= idx + IW'(1);
          end else begin
            idx   <= '0;
            k     <= '0;
            n     <= k;
            sb    <= !sb;
            plane <= plane_t'(3'(plane + 3'd1));
          end
        end
        ST_EMIT_WAIT: out_v <= 1'b1;
        ST_EMPTY:     out_v <= 1'b1;
        ST_EMIT_HOLD: begin
          if (!out_stall) begin
            out_v <= 1'b0;
            idx   <= idx + IW'(1);
            if (olast) begin
              n      <= '0;
              all_in <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers; these carry no reset.
  always_ff @(posedge clk) begin
    case (st)
      ST_CUR_WAIT: cur <= rd_data;
      ST_NXT_WAIT: nxt <= rd_data;
      ST_DECIDE: begin
        rem  <= {2'b00, (fcur[33] ? -fcur : fcur)};
        dvs  <= den[34] ? 35'(-den) : 35'(den);
        q    <= '0;
        dcnt <= '0;
        fld  <= 2'd0;
        ivtx <= cur;
      end
      ST_DIV: begin
        rem  <= ge ? trial - {1'b0, dvs} : trial;
        q    <= {q[TW-2:0], ge};
        dcnt <= dcnt + DCW'(1);
      end
      ST_MUL: prod <= PW'(diff * $signed({1'b0, q}));
      ST_ACC: begin
        case (fld)
          2'd0:    ivtx.x <= sum[31:0];
          2'd1:    ivtx.y <= sum[31:0];
          2'd2:    ivtx.z <= sum[31:0];
          default: ivtx.s <= sum[31:0];
        endcase
        fld <= fld + 2'd1;
      end
      ST_NEXT: cur <= nxt;
      ST_EMIT_WAIT: begin
        ox        <= rd_data.x;
        oy        <= rd_data.y;
        oz        <= rd_data.z;
        ow        <= rd_data.w;
        oshade    <= rd_data.s;
        olast     <= idx + IW'(1) == n;
        empty_res <= 1'b0;
      end
      ST_EMPTY: begin
        ox        <= '0;
        oy        <= '0;
        oz        <= '0;
        ow        <= '0;
        oshade    <= '0;
        olast     <= 1'b1;
        empty_res <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid = out_v;

`include "polygon_frustum_clipper_macros.svh"

  `PCC_ASSERT_SAME(a_out_hold, clk, rst, out_v, st == ST_EMIT_HOLD, "result shown outside hold")
  `PCC_ASSERT_SAME(a_k_room, clk, rst, 1'b1, (k <= IW'(MAX_RES)) && (n <= IW'(MAX_RES)), "pass overran bank")
  `PCC_ASSERT_SAME(a_t_range, clk, rst, st == ST_MUL, q <= TW'(ONE32), "interpolation factor above one")
  `PCC_ASSERT_NEXT(a_pop_load, clk, rst, q_pop && q_data.last, st != ST_LOAD, "polygon end not taken")

endmodule

FILE: rtl/polygon_frustum_clipper.sv
// ---------------------------------------------------------------------------
// Polygon frustum clipper
// Clips one polygon at a time against the front, left, right, bottom and
// top planes and streams out the surviving vertices.
// ---------------------------------------------------------------------------
// Vertices enter one per transfer until a transfer with vlast set closes the
// polygon. The front end takes a vertex in every cycle while its four-entry
// queue has room; the clip engine drains the queue one vertex a cycle, then
// works on the closed polygon alone. A polygon whose vertices all lie inside
// is sent on unchanged. Otherwise the polygon goes through up to five clip
// passes; each intersection is found by the bit-serial divider (one quotient
// bit a cycle) and the shared multiplier, used once for each of x, y, z and
// intensity. Vertices beyond MAX_VERTICES are dropped, and a pass keeps at
// most MAX_VERTICES + 5 vertices. A polygon that vanishes gives one transfer
// with empty_res and olast set and zero vertex fields. near_plane_z may be
// written only while the block is idle.
module polygon_frustum_clipper #(
  parameter int MAX_VERTICES = pfc_pkg::MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = pfc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] vx,
  input  logic signed [31:0] vy,
  input  logic signed [31:0] vz,
  input  logic signed [31:0] vw,
  input  logic signed [31:0] vshade,
  input  logic               vlast,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] ox,
  output logic signed [31:0] oy,
  output logic signed [31:0] oz,
  output logic signed [31:0] ow,
  output logic signed [31:0] oshade,
  output logic               olast,
  output logic               empty_res
);
  import pfc_pkg::*;

  // One tenth of one in the fixed-point format.
  localparam logic [31:0] NEAR_RESET = 32'((64'(1) << FRAC_BITS) / 10);

  logic signed [31:0] near_plane_z;
  logic     q_push, q_full, q_pop, q_empty;
  q_entry_t q_in, q_out;

  // The front plane depth register; it feeds both the classifier and the
  // clip engine.
  always_ff @(posedge clk) begin
    if (rst) near_plane_z <= $signed(NEAR_RESET);
    else if (cfg_we) near_plane_z <= $signed(cfg_wdata);
  end

  pfc_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk(clk), .rst(rst), .nz(near_plane_z),
    .in_valid(in_valid), .in_stall(in_stall),
    .vx(vx), .vy(vy), .vz(vz), .vw(vw), .vshade(vshade), .vlast(vlast),
    .q_full(q_full), .q_push(q_push), .q_data(q_in)
  );

  pfc_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(q_push), .wdata(q_in), .full(q_full),
    .pop(q_pop), .rdata(q_out), .empty(q_empty)
  );

  pfc_back #(.MAX_VERTICES(MAX_VERTICES), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .nz(near_plane_z),
    .q_empty(q_empty), .q_data(q_out), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall),
    .ox(ox), .oy(oy), .oz(oz), .ow(ow), .oshade(oshade),
    .olast(olast), .empty_res(empty_res)
  );

endmodule
